// ===== hw/rtl/c2d_pkg.sv =====
package c2d_pkg;

	// Default sizes of the stores and the kernel limit.
	localparam int unsigned WEIGHT_DEPTH_DEF     = 4096;
	localparam int unsigned PIXEL_DEPTH_DEF      = 4096;
	localparam int unsigned MAX_OUT_CHANNELS_DEF = 64;
	localparam int unsigned MAX_KERNEL_DEF       = 7;

	// Widths of the running weight and pixel indexes, set by the register widths.
	localparam int unsigned WIDX_W = 18;
	localparam int unsigned PIDX_W = 22;

	typedef enum logic [1:0] {
		FUNC_LOAD_WEIGHT = 2'd0,
		FUNC_LOAD_BIAS   = 2'd1,
		FUNC_LOAD_PIXEL  = 2'd2,
		FUNC_COMPUTE     = 2'd3
	} func_t;

	localparam logic [2:0] REG_IN_CHANNELS  = 3'd0;
	localparam logic [2:0] REG_IN_HEIGHT    = 3'd1;
	localparam logic [2:0] REG_IN_WIDTH     = 3'd2;
	localparam logic [2:0] REG_OUT_CHANNELS = 3'd3;
	localparam logic [2:0] REG_KERNEL_H     = 3'd4;
	localparam logic [2:0] REG_KERNEL_W     = 3'd5;
	localparam logic [2:0] REG_STRIDE       = 3'd6;
	localparam logic [2:0] REG_PADDING      = 3'd7;

	typedef struct packed {
		logic [4:0] in_channels;
		logic [6:0] in_height;
		logic [6:0] in_width;
		logic [6:0] out_channels;
		logic [2:0] kernel_height;
		logic [2:0] kernel_width;
		logic [2:0] stride;
		logic [1:0] padding;
	} cfg_t;

	// One tap issued to the multiply-accumulate pipeline.
	typedef struct packed {
		logic valid;
		logic last;
	} tap_t;

	// The request under way, as the result stage needs it.
	typedef struct packed {
		logic [5:0] co;
		logic [5:0] orow;
		logic [5:0] ocol;
		logic       bad;
		logic       bias_ok;
	} req_t;

endpackage

// ===== hw/rtl/c2d_store.sv =====
module c2d_store #(
	parameter int unsigned WEIGHT_DEPTH     = c2d_pkg::WEIGHT_DEPTH_DEF,
	parameter int unsigned PIXEL_DEPTH      = c2d_pkg::PIXEL_DEPTH_DEF,
	parameter int unsigned MAX_OUT_CHANNELS = c2d_pkg::MAX_OUT_CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          load,
	input  c2d_pkg::func_t                func,
	input  logic [11:0]                   addr,
	input  logic signed [15:0]            value,
	input  logic [c2d_pkg::WIDX_W-1:0]    widx,
	input  logic [c2d_pkg::PIDX_W-1:0]    pidx,
	input  logic [5:0]                    co,
	output logic signed [15:0]            w_rd,
	output logic signed [15:0]            p_rd,
	output logic signed [15:0]            b_rd
);

	localparam int unsigned WA = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
	localparam int unsigned PA = (PIXEL_DEPTH > 1) ? $clog2(PIXEL_DEPTH) : 1;
	localparam int unsigned BA = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;

	logic signed [15:0] wmem [WEIGHT_DEPTH];
	logic signed [15:0] pmem [PIXEL_DEPTH];
	logic signed [15:0] bmem [MAX_OUT_CHANNELS];

	logic w_we, p_we, b_we;

	// Loads beyond the depth of a store are dropped.
	assign w_we = load && (func == c2d_pkg::FUNC_LOAD_WEIGHT)
		&& ({20'd0, addr} < 32'(WEIGHT_DEPTH));
	assign p_we = load && (func == c2d_pkg::FUNC_LOAD_PIXEL)
		&& ({20'd0, addr} < 32'(PIXEL_DEPTH));
	assign b_we = load && (func == c2d_pkg::FUNC_LOAD_BIAS)
		&& ({20'd0, addr} < 32'(MAX_OUT_CHANNELS));

	always_ff @(posedge clk) begin
		if (w_we) begin
			wmem[WA'(addr)] <= value;
		end
		w_rd <= wmem[widx[WA-1:0]];
	end

	always_ff @(posedge clk) begin
		if (p_we) begin
			pmem[PA'(addr)] <= value;
		end
		p_rd <= pmem[pidx[PA-1:0]];
	end

	always_ff @(posedge clk) begin
		if (b_we) begin
			bmem[BA'(addr)] <= value;
		end
		b_rd <= bmem[BA'(co)];
	end

endmodule

// ===== hw/rtl/c2d_mac.sv =====
module c2d_mac (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clear,
	input  c2d_pkg::tap_t       tap,
	input  logic signed [15:0]  w_rd,
	input  logic signed [15:0]  p_rd,
	output logic signed [47:0]  acc,
	output logic                done
);

	c2d_pkg::tap_t      tap_s1;
	logic               vld_s2, last_s2;
	logic signed [31:0] prod_s2;
	logic signed [47:0] acc_q;
	logic               done_q;

	// The tap flags are registered in tap_s1 alongside the store read, in step with the read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s1  <= '0;
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			tap_s1  <= tap;
			vld_s2  <= tap_s1.valid;
			last_s2 <= tap_s1.last;
			done_q  <= last_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= w_rd * p_rd;
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + 48'(prod_s2);
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

// ===== hw/rtl/c2d_seq.sv =====
module c2d_seq #(
	parameter int unsigned WEIGHT_DEPTH     = c2d_pkg::WEIGHT_DEPTH_DEF,
	parameter int unsigned PIXEL_DEPTH      = c2d_pkg::PIXEL_DEPTH_DEF,
	parameter int unsigned MAX_OUT_CHANNELS = c2d_pkg::MAX_OUT_CHANNELS_DEF,
	parameter int unsigned MAX_KERNEL       = c2d_pkg::MAX_KERNEL_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [5:0]                    out_channel,
	input  logic [5:0]                    out_row,
	input  logic [5:0]                    out_col,
	input  c2d_pkg::cfg_t                 cfg,
	input  logic                          mac_done,
	output logic                          busy,
	output c2d_pkg::tap_t                 tap,
	output logic [c2d_pkg::WIDX_W-1:0]    widx,
	output logic [c2d_pkg::PIDX_W-1:0]    pidx,
	output c2d_pkg::req_t                 req
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SETUP1 = 6'b000010,
		ST_SETUP2 = 6'b000100,
		ST_SETUP3 = 6'b001000,
		ST_RUN    = 6'b010000,
		ST_WAIT   = 6'b100000
	} state_t;

	localparam int unsigned KCAP = (MAX_KERNEL > 7) ? 7 : MAX_KERNEL;

	state_t state_q;

	logic [5:0]  co_q, orow_q, ocol_q;
	logic [8:0]  ys_q, xs_q;
	logic [10:0] m1_q;
	logic [13:0] m2_q;
	logic [13:0] hw_q;
	logic        bad_q;
	logic signed [10:0] y0_q, x0_q, y_q;
	logic signed [19:0] rowoff0_q, rowoff_q;
	logic [19:0] cbase_q;
	logic [c2d_pkg::WIDX_W-1:0] widx_q;
	logic [4:0]  ci_q;
	logic [2:0]  ky_q, kx_q;

	logic [2:0]  kh, kw, s_eff;
	logic        empty;
	logic        last_kx, last_ky, last_ci;
	logic signed [10:0] x_cur;
	logic signed [c2d_pkg::PIDX_W-1:0] pidx_s;
	logic        y_in, x_in, tap_ok;
	logic [9:0]  row_need, row_span, col_need, col_span;

	assign kh    = (cfg.kernel_height > 3'(KCAP)) ? 3'(KCAP) : cfg.kernel_height;
	assign kw    = (cfg.kernel_width > 3'(KCAP)) ? 3'(KCAP) : cfg.kernel_width;
	assign s_eff = (cfg.stride == 3'd0) ? 3'd1 : cfg.stride;
	assign empty = (cfg.in_channels == 5'd0) || (kh == 3'd0) || (kw == 3'd0);

	// A position is inside the output when pos*stride + kernel <= size + 2*padding.
	assign row_need = {1'b0, ys_q} + {7'd0, kh};
	assign row_span = {3'd0, cfg.in_height} + {7'd0, cfg.padding, 1'b0};
	assign col_need = {1'b0, xs_q} + {7'd0, kw};
	assign col_span = {3'd0, cfg.in_width} + {7'd0, cfg.padding, 1'b0};

	assign last_kx = (kx_q == kw - 3'd1);
	assign last_ky = (ky_q == kh - 3'd1);
	assign last_ci = (ci_q == cfg.in_channels - 5'd1);

	assign x_cur  = x0_q + $signed({8'd0, kx_q});
	assign pidx_s = $signed({2'd0, cbase_q}) + c2d_pkg::PIDX_W'(rowoff_q)
		+ c2d_pkg::PIDX_W'(x_cur);
	assign y_in   = (y_q >= 0) && (y_q < $signed({4'd0, cfg.in_height}));
	assign x_in   = (x_cur >= 0) && (x_cur < $signed({4'd0, cfg.in_width}));
	assign tap_ok = y_in && x_in
		&& (32'(widx_q) < 32'(WEIGHT_DEPTH))
		&& (32'(pidx_s) < 32'(PIXEL_DEPTH));

	always_comb begin
		tap = '0;
		case (state_q)
			ST_SETUP3: begin
				tap.valid = 1'b0;
				tap.last  = bad_q || empty;
			end
			ST_RUN: begin
				tap.valid = tap_ok;
				tap.last  = last_kx && last_ky && last_ci;
			end
			default: begin
				tap = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (go) begin
						state_q <= ST_SETUP1;
					end
				end
				ST_SETUP1: begin
					state_q <= ST_SETUP2;
				end
				ST_SETUP2: begin
					state_q <= ST_SETUP3;
				end
				ST_SETUP3: begin
					state_q <= (bad_q || empty) ? ST_WAIT : ST_RUN;
				end
				ST_RUN: begin
					if (last_kx && last_ky && last_ci) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (mac_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (go) begin
					co_q   <= out_channel;
					orow_q <= out_row;
					ocol_q <= out_col;
				end
			end
			ST_SETUP1: begin
				ys_q <= 9'(orow_q) * 9'(s_eff);
				xs_q <= 9'(ocol_q) * 9'(s_eff);
				m1_q <= 11'(co_q) * 11'(cfg.in_channels);
				hw_q <= 14'(cfg.in_height) * 14'(cfg.in_width);
			end
			ST_SETUP2: begin
				bad_q   <= ({1'b0, co_q} >= cfg.out_channels)
					|| (row_need > row_span) || (col_need > col_span);
				y0_q    <= $signed({2'd0, ys_q}) - $signed({9'd0, cfg.padding});
				x0_q    <= $signed({2'd0, xs_q}) - $signed({9'd0, cfg.padding});
				m2_q    <= m1_q * 14'(kh);
				ci_q    <= '0;
				ky_q    <= '0;
				kx_q    <= '0;
				cbase_q <= '0;
			end
			ST_SETUP3: begin
				rowoff0_q <= 20'(y0_q) * 20'($signed({1'b0, cfg.in_width}));
				rowoff_q  <= 20'(y0_q) * 20'($signed({1'b0, cfg.in_width}));
				y_q       <= y0_q;
				widx_q    <= c2d_pkg::WIDX_W'(m2_q) * c2d_pkg::WIDX_W'(kw);
			end
			ST_RUN: begin
				widx_q <= widx_q + 1'b1;
				if (!last_kx) begin
					kx_q <= kx_q + 3'd1;
				end else begin
					kx_q <= '0;
					if (!last_ky) begin
						ky_q     <= ky_q + 3'd1;
						y_q      <= y_q + 11'sd1;
						rowoff_q <= rowoff_q + $signed({13'd0, cfg.in_width});
					end else begin
						ky_q     <= '0;
						y_q      <= y0_q;
						rowoff_q <= rowoff0_q;
						ci_q     <= ci_q + 5'd1;
						cbase_q  <= cbase_q + 20'(hw_q);
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign busy        = (state_q != ST_IDLE);
	assign widx        = widx_q;
	assign pidx        = pidx_s;
	assign req.co      = co_q;
	assign req.orow    = orow_q;
	assign req.ocol    = ocol_q;
	assign req.bad     = bad_q;
	assign req.bias_ok = ({26'd0, co_q} < 32'(MAX_OUT_CHANNELS));

endmodule

// ===== hw/rtl/conv2d_forward_stride_pad.sv =====
// Multichannel 2D convolution engine with zero padding, stride and bias for one
// image. Weights, biases and pixels (Q8.8) are loaded one beat at a time through
// start with func set to a load code; a load leaves busy low and gives no result,
// and a load whose addr lies beyond its store is dropped. A compute beat names an
// output channel, row and column; busy then stays high while one shared
// multiply-accumulate unit steps through every tap of every input channel, one tap
// a cycle, and the full-precision Q32.16 sum with the bias added comes back on sum,
// held until the next result, under the one-cycle done strobe. The sequencer goes
// through ST_SETUP1 to ST_SETUP3, then runs the tap loop over the memory ports;
// done is registered from mac_done at the end of the multiply-accumulate pipeline.
// A position outside the output, or beyond out_channels, skips the tap loop and
// returns with bad_position set and sum zero.
// The receiver cannot stall: done is a one-cycle strobe and must be taken when it
// appears. The stores are not cleared by reset, so an entry must be loaded before
// a compute beat reads it. Configuration sits behind an APB-style port at byte
// address 4 * index and may only be written while busy is low; pready is tied high.
module conv2d_forward_stride_pad #(
	parameter int unsigned WEIGHT_DEPTH     = c2d_pkg::WEIGHT_DEPTH_DEF,
	parameter int unsigned PIXEL_DEPTH      = c2d_pkg::PIXEL_DEPTH_DEF,
	parameter int unsigned MAX_OUT_CHANNELS = c2d_pkg::MAX_OUT_CHANNELS_DEF,
	parameter int unsigned MAX_KERNEL       = c2d_pkg::MAX_KERNEL_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// Command channel.
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          func,
	input  logic [11:0]         addr,
	input  logic signed [15:0]  value,
	input  logic [5:0]          out_channel,
	input  logic [5:0]          out_row,
	input  logic [5:0]          out_col,
	// Result channel.
	output logic                done,
	output logic signed [47:0]  sum,
	output logic [5:0]          out_channel_echo,
	output logic [5:0]          out_row_echo,
	output logic [5:0]          out_col_echo,
	output logic                bad_position,
	// Configuration port.
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	c2d_pkg::cfg_t  cfg_q;
	c2d_pkg::func_t func_in;
	c2d_pkg::tap_t  tap;
	c2d_pkg::req_t  req;

	logic                        accept, go, load;
	logic [c2d_pkg::WIDX_W-1:0]  widx;
	logic [c2d_pkg::PIDX_W-1:0]  pidx;
	logic signed [15:0]          w_rd, p_rd, b_rd;
	logic signed [47:0]          acc;
	logic                        mac_done;
	logic signed [47:0]          bias_term;

	logic                        done_q;
	logic signed [47:0]          sum_q;
	logic [5:0]                  co_echo_q, row_echo_q, col_echo_q;
	logic                        bad_q;

	// A beat is taken whenever start is high and no compute is under way.
	assign func_in = c2d_pkg::func_t'(func);
	assign accept  = start && !busy;
	assign go      = accept && (func_in == c2d_pkg::FUNC_COMPUTE);
	assign load    = accept && (func_in != c2d_pkg::FUNC_COMPUTE);

	// Configuration registers. Writes keep only the bits each register holds.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_channels   <= 5'd1;
			cfg_q.in_height     <= 7'd8;
			cfg_q.in_width      <= 7'd8;
			cfg_q.out_channels  <= 7'd1;
			cfg_q.kernel_height <= 3'd3;
			cfg_q.kernel_width  <= 3'd3;
			cfg_q.stride        <= 3'd1;
			cfg_q.padding       <= 2'd0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[4:2])
				c2d_pkg::REG_IN_CHANNELS:  cfg_q.in_channels   <= pwdata[4:0];
				c2d_pkg::REG_IN_HEIGHT:    cfg_q.in_height     <= pwdata[6:0];
				c2d_pkg::REG_IN_WIDTH:     cfg_q.in_width      <= pwdata[6:0];
				c2d_pkg::REG_OUT_CHANNELS: cfg_q.out_channels  <= pwdata[6:0];
				c2d_pkg::REG_KERNEL_H:     cfg_q.kernel_height <= pwdata[2:0];
				c2d_pkg::REG_KERNEL_W:     cfg_q.kernel_width  <= pwdata[2:0];
				c2d_pkg::REG_STRIDE:       cfg_q.stride        <= pwdata[2:0];
				c2d_pkg::REG_PADDING:      cfg_q.padding       <= pwdata[1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			c2d_pkg::REG_IN_CHANNELS:  prdata = {27'd0, cfg_q.in_channels};
			c2d_pkg::REG_IN_HEIGHT:    prdata = {25'd0, cfg_q.in_height};
			c2d_pkg::REG_IN_WIDTH:     prdata = {25'd0, cfg_q.in_width};
			c2d_pkg::REG_OUT_CHANNELS: prdata = {25'd0, cfg_q.out_channels};
			c2d_pkg::REG_KERNEL_H:     prdata = {29'd0, cfg_q.kernel_height};
			c2d_pkg::REG_KERNEL_W:     prdata = {29'd0, cfg_q.kernel_width};
			c2d_pkg::REG_STRIDE:       prdata = {29'd0, cfg_q.stride};
			c2d_pkg::REG_PADDING:      prdata = {30'd0, cfg_q.padding};
			default:                   prdata = '0;
		endcase
	end

	// The sequencer walks channels, kernel rows and kernel columns, and hands one
	// weight and one pixel address a cycle to the stores.
	c2d_seq #(
		.WEIGHT_DEPTH     (WEIGHT_DEPTH),
		.PIXEL_DEPTH      (PIXEL_DEPTH),
		.MAX_OUT_CHANNELS (MAX_OUT_CHANNELS),
		.MAX_KERNEL       (MAX_KERNEL)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (go),
		.out_channel (out_channel),
		.out_row     (out_row),
		.out_col     (out_col),
		.cfg         (cfg_q),
		.mac_done    (mac_done),
		.busy        (busy),
		.tap         (tap),
		.widx        (widx),
		.pidx        (pidx),
		.req         (req)
	);

	c2d_store #(
		.WEIGHT_DEPTH     (WEIGHT_DEPTH),
		.PIXEL_DEPTH      (PIXEL_DEPTH),
		.MAX_OUT_CHANNELS (MAX_OUT_CHANNELS)
	) u_store (
		.clk   (clk),
		.load  (load),
		.func  (func_in),
		.addr  (addr),
		.value (value),
		.widx  (widx),
		.pidx  (pidx),
		.co    (req.co),
		.w_rd  (w_rd),
		.p_rd  (p_rd),
		.b_rd  (b_rd)
	);

	// The shared multiply-accumulate unit; its sum is cleared as a compute beat
	// is accepted and is final in the cycle that mac_done is high.
	c2d_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (go),
		.tap    (tap),
		.w_rd   (w_rd),
		.p_rd   (p_rd),
		.acc    (acc),
		.done   (mac_done)
	);

	// The bias is Q8.8 and the sum Q32.16, so the bias is shifted up by eight
	// bits. A channel beyond the bias store adds nothing.
	assign bias_term = req.bias_ok ? {{24{b_rd[15]}}, b_rd, 8'd0} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= mac_done;
		end
	end

	always_ff @(posedge clk) begin
		if (mac_done) begin
			sum_q      <= req.bad ? '0 : acc + bias_term;
			co_echo_q  <= req.co;
			row_echo_q <= req.orow;
			col_echo_q <= req.ocol;
			bad_q      <= req.bad;
		end
	end

	assign done             = done_q;
	assign sum              = sum_q;
	assign out_channel_echo = co_echo_q;
	assign out_row_echo     = row_echo_q;
	assign out_col_echo     = col_echo_q;
	assign bad_position     = bad_q;

endmodule

// ===== hw/rtl/c2d_check.sv =====
module c2d_check (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [1:0]         func,
	input logic               done,
	input logic signed [47:0] sum,
	input logic               bad_position
);

	// A result only appears once the block has gone idle again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// A compute beat occupies the block from the next cycle on.
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (func == c2d_pkg::FUNC_COMPUTE)) |=> busy)
		else $error("compute beat did not raise busy");

	// A load beat never occupies the block.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (func != c2d_pkg::FUNC_COMPUTE)) |=> !busy)
		else $error("load beat raised busy");

	// Each result is a single-cycle strobe.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// A position outside the output carries a zero sum.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && bad_position) |-> (sum == 48'sd0))
		else $error("bad position with non-zero sum");

endmodule

bind conv2d_forward_stride_pad c2d_check u_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.func         (func),
	.done         (done),
	.sum          (sum),
	.bad_position (bad_position)
);
